/* src/dqr_pkg.sv */
`timescale 1ns / 1ps

package dqr_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    // broadcast to every cell; strobes are qualified by accept, pushes also by not full and pop front by not empty
    typedef struct packed {
        logic                     push_front;
        logic                     push_back;
        logic                     pop_front;
        logic                     remove;
        logic signed [DATA_W-1:0] value;
    } dqr_ctl_t;

    // where a cell sits relative to the current fill count
    typedef struct packed {
        logic occupied;
        logic tail;
        logic last;
    } dqr_pos_t;

    // count modulo 2**OCC_W, for any CNT_W
    function automatic logic [OCC_W-1:0] occ_of(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, cnt};
        return wide[OCC_W-1:0];
    endfunction

endpackage

/* src/dqr_if.sv */
`timescale 1ns / 1ps

interface dqr_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [dqr_pkg::CMD_W-1:0]         cmd;
    logic signed [dqr_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface dqr_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [dqr_pkg::STAT_W-1:0]        status;
    logic signed [dqr_pkg::DATA_W-1:0] data;
    logic [dqr_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output status, output data, output occupancy, input ready);
    modport sink   (input valid, input status, input data, input occupancy, output ready);
endinterface

/* src/dqr_cell.sv */
`timescale 1ns / 1ps

module dqr_cell (
    input  logic                              clk,
    input  dqr_pkg::dqr_ctl_t                 ctl,
    input  dqr_pkg::dqr_pos_t                 pos,
    input  logic signed [dqr_pkg::DATA_W-1:0] prev_data,
    input  logic signed [dqr_pkg::DATA_W-1:0] next_data,
    input  logic                              hit_in,
    output logic                              hit_out,
    output logic signed [dqr_pkg::DATA_W-1:0] data,
    output logic signed [dqr_pkg::DATA_W-1:0] tap
);

    logic signed [dqr_pkg::DATA_W-1:0] data_reg;
    logic signed [dqr_pkg::DATA_W-1:0] data_next;
    logic                              match;

    assign match   = pos.occupied && (data_reg == ctl.value);
    // hit_out: this cell or one nearer the front holds the first match
    assign hit_out = hit_in || match;
    assign data    = data_reg;
    assign tap     = pos.last ? data_reg : '0;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.push_front)
        begin
            data_next = prev_data;
        end
        else if (ctl.push_back)
        begin
            if (pos.tail)
            begin
                data_next = ctl.value;
            end
        end
        else if (ctl.pop_front)
        begin
            data_next = next_data;
        end
        else if (ctl.remove)
        begin
            if (hit_out)
            begin
                data_next = next_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

/* src/deque_with_remove_by_value.sv */
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values held in a row of cells,
// front at cell 0. Each command beat (push front, push back, pop front, pop
// back, remove first match from the front) is executed in the cycle it is
// accepted and yields exactly one registered result beat: status, the value
// moved, and the occupancy after the step. A new command is taken every
// cycle as long as the result register is empty or being drained, so the
// sustained rate is one command per clock. The critical path is the remove
// search: every cell compares its entry against the value in parallel, and
// the first-match flag ripples down the row so the matching cell and each behind it
// takes its neighbor's entry. A push into a full queue is dropped with status
// full; a pop or remove on an empty queue reports empty; unused command codes
// report ok with data zero and change nothing. Occupancy is the count modulo 32.

module deque_with_remove_by_value (
    input logic       clk,
    input logic       rst_n,
    dqr_cmd_if.sink   req,
    dqr_rsp_if.source rsp
);

    localparam int DEPTH = dqr_pkg::DEPTH;

    logic [dqr_pkg::CNT_W-1:0]  count_reg;
    logic [dqr_pkg::CNT_W-1:0]  count_next;
    logic                       res_valid_reg;
    logic [dqr_pkg::STAT_W-1:0] status_reg;
    logic [dqr_pkg::STAT_W-1:0] status_next;
    logic signed [dqr_pkg::DATA_W-1:0] data_reg;
    logic signed [dqr_pkg::DATA_W-1:0] data_next;
    logic [dqr_pkg::OCC_W-1:0]  occ_reg;

    logic accept;
    logic full;
    logic empty;
    logic found;
    logic signed [dqr_pkg::DATA_W-1:0] back_data;

    dqr_pkg::dqr_ctl_t ctl;
    dqr_pkg::dqr_pos_t pos [DEPTH];

    logic signed [dqr_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic signed [dqr_pkg::DATA_W-1:0] cell_tap  [DEPTH];
    logic                              hit       [DEPTH+1];

    assign req.ready = !res_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == dqr_pkg::CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = hit[DEPTH];

    // pushes need room and pop front an entry; every accepted remove is strobed
    always_comb
    begin
        ctl.value      = req.value;
        ctl.push_front = accept && (req.cmd == dqr_pkg::CMD_PUSH_FRONT) && !full;
        ctl.push_back  = accept && (req.cmd == dqr_pkg::CMD_PUSH_BACK) && !full;
        ctl.pop_front  = accept && (req.cmd == dqr_pkg::CMD_POP_FRONT) && !empty;
        ctl.remove     = accept && (req.cmd == dqr_pkg::CMD_REMOVE);
    end

    assign hit[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [dqr_pkg::DATA_W-1:0] prev_d;
            logic signed [dqr_pkg::DATA_W-1:0] next_d;

            always_comb
            begin
                pos[gi].occupied = (dqr_pkg::CNT_W'(gi) < count_reg);
                pos[gi].tail     = (dqr_pkg::CNT_W'(gi) == count_reg);
                pos[gi].last     = (dqr_pkg::CNT_W'(gi + 1) == count_reg);
            end

            if (gi == 0)
            begin : g_head
                assign prev_d = req.value;
            end
            else
            begin : g_body
                assign prev_d = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_end
                assign next_d = '0;
            end
            else
            begin : g_mid
                assign next_d = cell_data[gi+1];
            end

            dqr_cell u_cell (
                .clk       (clk),
                .ctl       (ctl),
                .pos       (pos[gi]),
                .prev_data (prev_d),
                .next_data (next_d),
                .hit_in    (hit[gi]),
                .hit_out   (hit[gi+1]),
                .data      (cell_data[gi]),
                .tap       (cell_tap[gi])
            );
        end
    endgenerate

    // one-hot select of the back entry: only the last occupied cell drives its tap
    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | cell_tap[i];
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        status_next = dqr_pkg::ST_OK;
        data_next   = '0;
        case (req.cmd)
            dqr_pkg::CMD_PUSH_FRONT,
            dqr_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = dqr_pkg::ST_FULL;
                end
                else
                begin
                    data_next  = req.value;
                    count_next = count_reg + 1'b1;
                end
            end
            dqr_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = dqr_pkg::ST_EMPTY;
                end
                else
                begin
                    data_next  = cell_data[0];
                    count_next = count_reg - 1'b1;
                end
            end
            dqr_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = dqr_pkg::ST_EMPTY;
                end
                else
                begin
                    data_next  = back_data;
                    count_next = count_reg - 1'b1;
                end
            end
            dqr_pkg::CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = dqr_pkg::ST_EMPTY;
                end
                else if (found)
                begin
                    data_next  = req.value;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = dqr_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = dqr_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            occ_reg    <= dqr_pkg::occ_of(count_next);
        end
    end

    assign rsp.valid     = res_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.data      = data_reg;
    assign rsp.occupancy = occ_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dqr_pkg::CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (status_reg == dqr_pkg::ST_FULL) |-> full)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && (status_reg == dqr_pkg::ST_EMPTY) |-> empty)
        else $error("empty status with entries stored");

    a_no_hit_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !found)
        else $error("match reported on empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.push_front || ctl.push_back) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the count");

endmodule
